// File: rtl/ogpm_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy grid point marker package
// Shared types and constants for the grid marker and its cell memory.
// ----------------------------------------------------------------------------
package ogpm_pkg;

   // Input word command codes. Code 3 carries no operation.
   typedef enum logic [1:0] {
      CMD_POINT = 2'd0,
      CMD_ROBOT = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Configuration register indexes (byte address divided by four).
   localparam logic [2:0] REG_COS_HEADING     = 3'd0;
   localparam logic [2:0] REG_SIN_HEADING     = 3'd1;
   localparam logic [2:0] REG_POSE_X          = 3'd2;
   localparam logic [2:0] REG_POSE_Y          = 3'd3;
   localparam logic [2:0] REG_CELLS_PER_METRE = 3'd4;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // Values written into an empty cell.
   localparam logic [7:0] POINT_MARK = 8'd50;
   localparam logic [7:0] ROBOT_MARK = 8'd240;

   // Shared multiplier: 32-bit signed by 17-bit signed.
   localparam int MUL_AW = 32;
   localparam int MUL_BW = 17;
   localparam int MUL_W  = MUL_AW + MUL_BW;

   // Width of a stored column or row. A robot cell coordinate stays below 2^13.
   localparam int POS_W = 13;

   // Point coordinates are the product shifted by 32, robot ones by 18.
   localparam int POINT_SHIFT = 32;
   localparam int ROBOT_SHIFT = 18;

   typedef struct packed {
      logic rd;
      logic wr;
   } ram_ctl_type;

endpackage

// File: rtl/ogpm_cell_ram.sv
// ----------------------------------------------------------------------------
// Occupancy grid cell memory
// Single-port byte memory with registered read data and a clearing sweep
// that zeroes every cell after reset.
// ----------------------------------------------------------------------------
module ogpm_cell_ram
   import ogpm_pkg::*;
#(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  ram_ctl_type   ctl,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata,
   output logic          ready
);

   logic [7:0]    cells [DEPTH];
   logic [7:0]    rdata_ff;
   logic          clearing_ff;
   logic          clearing_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // The sweep owns the write port until the last cell is zeroed.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = AW'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      wr_en   = clearing_ff | ctl.wr;
      wr_addr = clearing_ff ? clr_addr_ff : addr;
      wr_data = clearing_ff ? 8'd0 : wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
      if (ctl.rd) begin
         rdata_ff <= cells[addr];
      end
   end

   assign rdata = rdata_ff;
   assign ready = ~clearing_ff;

endmodule

// File: rtl/occupancy_grid_point_marker.sv
// ----------------------------------------------------------------------------
// Occupancy grid point marker
// Byte-cell occupancy grid that places rotated and scaled sensor points and
// the robot pose into a memory, with write-if-empty marking and cell reads.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word contents
//   req_      in         req_valid/req_stall  command, point_x, point_y, read_index
//   rsp_      out        rsp_valid/rsp_stall  cell_index, in_bounds, cell_written,
//                                             cell_value
//   csr_      in/out     APB, pready high     five 16-bit registers at 4*i
//
// A point word holds the block through the rotation, scaling and index
// steps, the memory read and the write-back; a robot word skips the rotation,
// a read word goes straight to the read, and an unused command is dropped
// on acceptance. The single shared 32x17 multiplier (four products for the
// rotation, two for the scaling) and the registered memory read followed by
// a write-back step dictate this sequence. After reset the block sweeps the
// cell memory once, one cell per cycle, and holds req_stall high until the
// sweep ends; register writes are taken at all times. A stalled result waits
// in the output register; the next word is accepted meanwhile and finishes
// up to its write-back, where it waits.
module occupancy_grid_point_marker
   import ogpm_pkg::*;
#(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic [13:0]        req_read_index,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_cell_index,
   output logic               rsp_in_bounds,
   output logic               rsp_cell_written,
   output logic [7:0]         rsp_cell_value,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   // The grid holds GRID_WIDTH*GRID_HEIGHT cells. A linear index is kept wide
   // enough for a robot row times the width plus a robot column, which may
   // run past the grid before the range test.
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int LIN_W = POS_W + $clog2(GRID_WIDTH) + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL,
      S_INDEX,
      S_READ,
      S_UPDATE
   } state_type;

   // Steps of the shared multiplier. A robot word starts at STEP_SCALE_X.
   typedef enum logic [2:0] {
      STEP_PX_COS,
      STEP_PY_SIN,
      STEP_PY_COS,
      STEP_PX_SIN,
      STEP_SCALE_X,
      STEP_SCALE_Y,
      STEP_CHECK_Y
   } step_type;

   // Configuration registers.
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic signed [15:0] pose_x_ff;
   logic signed [15:0] pose_y_ff;
   logic [15:0]        cpm_ff;
   logic               csr_write;

   // Control and result registers.
   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [13:0]        rsp_index_ff, rsp_index_in;
   logic               rsp_bounds_ff, rsp_bounds_in;
   logic               rsp_written_ff, rsp_written_in;
   logic [7:0]         rsp_value_ff, rsp_value_in;

   // Datapath registers.
   cmd_type            cmd_ff, cmd_in;
   logic signed [15:0] px_ff, px_in;
   logic signed [15:0] py_ff, py_in;
   logic signed [31:0] wx_ff, wx_in;
   logic signed [31:0] wy_ff, wy_in;
   logic signed [MUL_W-1:0] mul_ff, mul_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic               xok_ff, xok_in;
   logic               yok_ff, yok_in;
   logic [LIN_W-1:0]   lin_ff, lin_in;
   logic               ok_ff, ok_in;

   // Shared multiplier operands.
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_BW-1:0] cpm_b;
   logic signed [31:0]       mul_lo;
   logic signed [31:0]       pose_x_q24;
   logic signed [31:0]       pose_y_q24;
   logic [LIN_W-1:0]         lin_calc;
   logic                     out_free;
   logic                     is_point;
   logic                     do_write;

   // Memory interface.
   ram_ctl_type        ram_ctl;
   logic [7:0]         ram_rdata;
   logic [7:0]         ram_wdata;
   logic               ram_ready;

   // A point coordinate is valid when the product is positive and its
   // integer part lies strictly between zero and the limit. A negative
   // product always truncates to a value at or below zero, so the floor
   // taken by the slice needs no rounding correction here.
   function automatic logic point_in_range(input logic [MUL_BW-1:0] v,
                                           input logic [MUL_BW-1:0] lim);
      point_in_range = ~v[MUL_BW-1] && (v != '0) && (v < lim);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration port. Writes land at the access phase; reads are
   // returned from the same decode without wait states.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= 16'sd16384;
         sin_ff    <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         cpm_ff    <= 16'd1280;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_COS_HEADING:     cos_ff    <= csr_pwdata[15:0];
            REG_SIN_HEADING:     sin_ff    <= csr_pwdata[15:0];
            REG_POSE_X:          pose_x_ff <= csr_pwdata[15:0];
            REG_POSE_Y:          pose_y_ff <= csr_pwdata[15:0];
            REG_CELLS_PER_METRE: cpm_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_COS_HEADING:     csr_prdata = {16'd0, cos_ff};
         REG_SIN_HEADING:     csr_prdata = {16'd0, sin_ff};
         REG_POSE_X:          csr_prdata = {16'd0, pose_x_ff};
         REG_POSE_Y:          csr_prdata = {16'd0, pose_y_ff};
         REG_CELLS_PER_METRE: csr_prdata = {16'd0, cpm_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Shared multiplier. Each step forms one product that is registered in
   // mul_ff and on the following step is folded into a world coordinate or taken as a cell column or row.
   // ------------------------------------------------------------------------
   assign is_point   = (cmd_ff == CMD_POINT);
   assign cpm_b      = $signed({1'b0, cpm_ff});
   assign mul_lo     = $signed(mul_ff[31:0]);
   assign pose_x_q24 = 32'(pose_x_ff) <<< 14;
   assign pose_y_q24 = 32'(pose_y_ff) <<< 14;

   always_comb begin
      unique case (step_ff)
         STEP_PX_COS: begin
            mul_a = 32'(px_ff);
            mul_b = 17'(cos_ff);
         end
         STEP_PY_SIN: begin
            mul_a = 32'(py_ff);
            mul_b = 17'(sin_ff);
         end
         STEP_PY_COS: begin
            mul_a = 32'(py_ff);
            mul_b = 17'(cos_ff);
         end
         STEP_PX_SIN: begin
            mul_a = 32'(px_ff);
            mul_b = 17'(sin_ff);
         end
         STEP_SCALE_X: begin
            mul_a = is_point ? wx_ff : 32'(pose_x_ff);
            mul_b = cpm_b;
         end
         STEP_SCALE_Y: begin
            mul_a = is_point ? wy_ff : 32'(pose_y_ff);
            mul_b = cpm_b;
         end
         default: begin
            mul_a = 32'(px_ff);
            mul_b = 17'(cos_ff);
         end
      endcase
      mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   // Linear index of the computed cell.
   assign lin_calc = LIN_W'(LIN_W'(row_ff) * LIN_W'(GRID_WIDTH)) + LIN_W'(col_ff);

   // The result register frees up when it is empty or taken this cycle.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign do_write  = ok_ff && (cmd_ff != CMD_READ) && (ram_rdata == 8'd0);
   assign ram_wdata = (cmd_ff == CMD_ROBOT) ? ROBOT_MARK : POINT_MARK;

   // ------------------------------------------------------------------------
   // Sequencer and datapath next values.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      cmd_in         = cmd_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      wx_in          = wx_ff;
      wy_in          = wy_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      xok_in         = xok_ff;
      yok_in         = yok_ff;
      lin_in         = lin_ff;
      ok_in          = ok_ff;
      ram_ctl        = '0;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_bounds_in  = rsp_bounds_ff;
      rsp_written_in = rsp_written_ff;
      rsp_value_in   = rsp_value_ff;

      unique case (state_ff)
         S_CLEAR: begin
            if (ram_ready) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               px_in  = req_point_x;
               py_in  = req_point_y;
               lin_in = LIN_W'(req_read_index);
               ok_in  = (LIN_W'(req_read_index) < LIN_W'(CELLS));
               unique case (req_command)
                  CMD_POINT: begin
                     step_in  = STEP_PX_COS;
                     state_in = S_MUL;
                  end
                  CMD_ROBOT: begin
                     step_in  = STEP_SCALE_X;
                     state_in = S_MUL;
                  end
                  CMD_READ: begin
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end

         S_MUL: begin
            step_in = step_type'(3'(step_ff + 3'd1));
            unique case (step_ff)
               STEP_PY_SIN:  wx_in = pose_x_q24 + mul_lo;
               STEP_PY_COS:  wx_in = wx_ff - mul_lo;
               STEP_PX_SIN:  wy_in = pose_y_q24 + mul_lo;
               STEP_SCALE_X: wy_in = wy_ff + mul_lo;
               STEP_SCALE_Y: begin
                  if (is_point) begin
                     xok_in = point_in_range(mul_ff[MUL_W-1:POINT_SHIFT],
                                             MUL_BW'(GRID_WIDTH));
                     col_in = mul_ff[POINT_SHIFT +: POS_W];
                  end else begin
                     xok_in = ~mul_ff[MUL_W-1] && (mul_ff != '0);
                     col_in = mul_ff[ROBOT_SHIFT +: POS_W];
                  end
               end
               STEP_CHECK_Y: begin
                  if (is_point) begin
                     yok_in = point_in_range(mul_ff[MUL_W-1:POINT_SHIFT],
                                             MUL_BW'(GRID_HEIGHT));
                     row_in = mul_ff[POINT_SHIFT +: POS_W];
                  end else begin
                     yok_in = ~mul_ff[MUL_W-1] && (mul_ff != '0);
                     row_in = mul_ff[ROBOT_SHIFT +: POS_W];
                  end
                  state_in = S_INDEX;
               end
               default: ;
            endcase
         end

         S_INDEX: begin
            // A point cell is inside the grid once both coordinates pass.
            // A robot column is not bounded by the width, so beyond the sign tests
            // only the linear index decides.
            lin_in   = lin_calc;
            ok_in    = xok_ff && yok_ff &&
                       (is_point || (lin_calc < LIN_W'(CELLS)));
            state_in = S_READ;
         end

         S_READ: begin
            ram_ctl.rd = 1'b1;
            state_in   = S_UPDATE;
         end

         S_UPDATE: begin
            if (out_free) begin
               ram_ctl.wr     = do_write;
               rsp_valid_in   = 1'b1;
               rsp_index_in   = (ok_ff || cmd_ff == CMD_READ) ? lin_ff[13:0] : 14'd0;
               rsp_bounds_in  = ok_ff;
               rsp_written_in = do_write;
               if (!ok_ff) begin
                  rsp_value_in = 8'd0;
               end else if (do_write) begin
                  rsp_value_in = ram_wdata;
               end else begin
                  rsp_value_in = ram_rdata;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= STEP_PX_COS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff   <= rsp_index_in;
      rsp_bounds_ff  <= rsp_bounds_in;
      rsp_written_ff <= rsp_written_in;
      rsp_value_ff   <= rsp_value_in;
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      wx_ff  <= wx_in;
      wy_ff  <= wy_in;
      col_ff <= col_in;
      row_ff <= row_in;
      xok_ff <= xok_in;
      yok_ff <= yok_in;
      lin_ff <= lin_in;
      ok_ff  <= ok_in;
      if (state_ff == S_MUL) begin
         mul_ff <= mul_in;
      end
   end

   // Grid memory. Accesses never overlap: each word writes back before the
   // next one reads.
   ogpm_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_ram (
      .clock (clock),
      .reset (reset),
      .ctl   (ram_ctl),
      .addr  (lin_ff[AW-1:0]),
      .wdata (ram_wdata),
      .rdata (ram_rdata),
      .ready (ram_ready)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = rsp_index_ff;
   assign rsp_in_bounds    = rsp_bounds_ff;
   assign rsp_cell_written = rsp_written_ff;
   assign rsp_cell_value   = rsp_value_ff;

endmodule

// File: dv/ogpm_grid_checker.sv
// ----------------------------------------------------------------------------
// Occupancy grid checker
// Watches the request, result and register ports of the grid marker, keeps
// its own copy of the grid and the registers, and compares every result word
// with the cell update it predicts.
// ----------------------------------------------------------------------------
module ogpm_grid_checker
   import ogpm_pkg::*;
#(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic [13:0]        req_read_index,

   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [13:0]        rsp_cell_index,
   input  logic               rsp_in_bounds,
   input  logic               rsp_cell_written,
   input  logic [7:0]         rsp_cell_value,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   input  logic               csr_pready,

   output int                 mismatches,
   output int                 pending,
   output int                 compared
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CELL_COUNT   = GRID_WIDTH * GRID_HEIGHT;
   localparam int         POINT_FRAC   = 32;
   localparam int         ROBOT_FRAC   = 18;
   localparam logic [7:0] MARK_POINT   = 8'd50;
   localparam logic [7:0] MARK_ROBOT   = 8'd240;

   typedef struct packed {
      logic [13:0] index;
      logic        in_bounds;
      logic        written;
      logic [7:0]  value;
   } cell_outcome_type;

   logic [7:0]         occupancy [CELL_COUNT];
   cell_outcome_type   expected_cells [$];
   logic signed [15:0] cos_q;
   logic signed [15:0] sin_q;
   logic signed [15:0] pose_x_q;
   logic signed [15:0] pose_y_q;
   logic [15:0]        cells_per_metre_q;

   function automatic longint shift_toward_zero(input longint v, input int sh);
      if (v < 0) begin
         return -((-v) >> sh);
      end
      return v >> sh;
   endfunction

   // Write-if-empty on an index that already passed its bounds test.
   function automatic cell_outcome_type place_mark(input longint index,
                                                   input logic [7:0] mark);
      cell_outcome_type r;
      r.index     = index[13:0];
      r.in_bounds = 1'b1;
      r.written   = (occupancy[index] == 8'd0);
      if (r.written) begin
         occupancy[index] = mark;
      end
      r.value = occupancy[index];
      return r;
   endfunction

   function automatic cell_outcome_type predict_cell(input logic [1:0] cmd,
                                                     input logic signed [15:0] px,
                                                     input logic signed [15:0] py,
                                                     input logic [13:0] ridx);
      longint           k;
      longint           wx;
      longint           wy;
      longint           col;
      longint           row;
      longint           lin;
      cell_outcome_type r;
      r = '0;
      k = longint'(cells_per_metre_q);
      case (cmd)
         CMD_POINT: begin
            // Rotation and pose land in Q.24 metres, the scale in Q.32 cells.
            wx = longint'(px) * longint'(cos_q) - longint'(py) * longint'(sin_q)
                 + longint'(pose_x_q) * 16384;
            wy = longint'(py) * longint'(cos_q) + longint'(px) * longint'(sin_q)
                 + longint'(pose_y_q) * 16384;
            col = shift_toward_zero(wx * k, POINT_FRAC);
            row = shift_toward_zero(wy * k, POINT_FRAC);
            if (col > 0 && col < GRID_WIDTH && row > 0 && row < GRID_HEIGHT) begin
               r = place_mark(row * GRID_WIDTH + col, MARK_POINT);
            end
         end
         CMD_ROBOT: begin
            // Only the linear index is bounded, so a wide column runs into later rows.
            wx = longint'(pose_x_q) * k;
            wy = longint'(pose_y_q) * k;
            if (wx > 0 && wy > 0) begin
               col = wx >> ROBOT_FRAC;
               row = wy >> ROBOT_FRAC;
               lin = row * GRID_WIDTH + col;
               if (lin < CELL_COUNT) begin
                  r = place_mark(lin, MARK_ROBOT);
               end
            end
         end
         default: begin
            r.index     = ridx;
            r.in_bounds = (longint'(ridx) < CELL_COUNT);
            if (r.in_bounds) begin
               r.value = occupancy[ridx];
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t ns: %s: got %0d, expected %0d (result %0d)",
               $time, what, got, want, compared);
   endtask

   always @(posedge clock) begin
      cell_outcome_type seen;
      cell_outcome_type want;
      if (reset) begin
         expected_cells.delete();
         foreach (occupancy[i]) begin
            occupancy[i] = 8'd0;
         end
         cos_q             = 16'sd16384;
         sin_q             = 16'sd0;
         pose_x_q          = 16'sd0;
         pose_y_q          = 16'sd0;
         cells_per_metre_q = 16'd1280;
         mismatches        = 0;
         compared          = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               REG_COS_HEADING:     cos_q             = csr_pwdata[15:0];
               REG_SIN_HEADING:     sin_q             = csr_pwdata[15:0];
               REG_POSE_X:          pose_x_q          = csr_pwdata[15:0];
               REG_POSE_Y:          pose_y_q          = csr_pwdata[15:0];
               REG_CELLS_PER_METRE: cells_per_metre_q = csr_pwdata[15:0];
               default: ;
            endcase
         end
         // Results are checked before this edge's request is predicted, since a
         // word cannot come back in the cycle it is taken.
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_cell_index, rsp_in_bounds, rsp_cell_written, rsp_cell_value};
            if (expected_cells.size() == 0) begin
               report_mismatch("result word with nothing expected",
                               longint'(seen.index), longint'(0));
            end else begin
               want = expected_cells.pop_front();
               if (seen.index !== want.index)
                  report_mismatch("cell_index", longint'(seen.index),
                                  longint'(want.index));
               if (seen.in_bounds !== want.in_bounds)
                  report_mismatch("in_bounds", longint'(seen.in_bounds),
                                  longint'(want.in_bounds));
               if (seen.written !== want.written)
                  report_mismatch("cell_written", longint'(seen.written),
                                  longint'(want.written));
               if (seen.value !== want.value)
                  report_mismatch("cell_value", longint'(seen.value),
                                  longint'(want.value));
               compared++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_command)
               CMD_POINT, CMD_ROBOT, CMD_READ:
                  expected_cells.insert(expected_cells.size(),
                                        predict_cell(req_command, req_point_x,
                                                     req_point_y, req_read_index));
               default: ;
            endcase
         end
      end
      pending <= expected_cells.size();
   end

endmodule

// File: dv/tb_occupancy_grid_point_marker.sv
// ----------------------------------------------------------------------------
// Occupancy grid point marker testbench
// Drives point, robot, read and unused words into the grid marker under
// several register settings, with random gaps and result back-pressure, and
// lets a separate checker predict and compare every result word.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_point_marker;
   import ogpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         GRID_W          = 128;
   localparam int         GRID_H          = 128;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         NUM_PHASES      = 8;
   localparam int         PHASE_WORDS     = 48;
   // Outlasts a point word, the longest holder of the block; this is ample after the last
   // expected result before a register write or the final verdict.
   localparam int         SETTLE_CYCLES   = 20;
   localparam int         END_CYCLES      = 40;
   localparam int         SQUEEZE_CYCLES  = 300;
   // The longest correct quiet stretch is the clearing sweep of the grid after
   // reset; the limit takes that several times over.
   localparam int         WATCHDOG_LIMIT  = 80000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command    = CMD_READ;
   logic signed [15:0] req_point_x    = '0;
   logic signed [15:0] req_point_y    = '0;
   logic [13:0]        req_read_index = '0;

   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [13:0]        rsp_cell_index;
   logic               rsp_in_bounds;
   logic               rsp_cell_written;
   logic [7:0]         rsp_cell_value;

   logic               csr_psel       = 1'b0;
   logic               csr_penable    = 1'b0;
   logic               csr_pwrite     = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr      = '0;
   logic [CSR_DW-1:0]  csr_pwdata     = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   int                 grid_mismatches;
   int                 grid_pending;
   int                 grid_compared;

   // Stimulus shaping, shared between the sender and the receiver processes.
   int                 gap_percent     = 30;
   int                 stall_percent   = 25;
   bit                 quiet           = 1'b0;
   bit                 squeeze_pending = 1'b0;

   int                 point_words;
   int                 robot_words;
   int                 read_words;
   int                 unused_words;
   int                 settings_applied;
   int                 idle_cycles;

   // Recent sensor points, replayed so that marks land on occupied cells.
   logic [15:0]        seen_x [$];
   logic [15:0]        seen_y [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   occupancy_grid_point_marker #(
      .GRID_WIDTH (GRID_W),
      .GRID_HEIGHT(GRID_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_in_bounds   (rsp_in_bounds),
      .rsp_cell_written(rsp_cell_written),
      .rsp_cell_value  (rsp_cell_value),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   ogpm_grid_checker #(
      .GRID_WIDTH (GRID_W),
      .GRID_HEIGHT(GRID_H)
   ) grid_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_in_bounds   (rsp_in_bounds),
      .rsp_cell_written(rsp_cell_written),
      .rsp_cell_value  (rsp_cell_value),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatches      (grid_mismatches),
      .pending         (grid_pending),
      .compared        (grid_compared)
   );

   // The watchdog counts cycles in which no word, result or register write is
   // taken. A hang anywhere, including a result that never shows up while the
   // checker still waits for it, ends the run here.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result back-pressure. Stalls come in random bursts, separated
   // by free runs. Once per run the receiver holds off for a long stretch so
   // that the block fills up and pushes back on its input. In the quiet tail
   // it never stalls.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_pending) begin
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_pending = 1'b0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (quiet || $urandom_range(0, 99) >= stall_percent) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   // One register write: a setup phase, an access phase, then an idle phase
   // so that back-to-back writes never touch psel twice in one time step.
   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_setting(input logic [15:0] c, input logic [15:0] s,
                                input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] k);
      write_register(REG_COS_HEADING, c);
      write_register(REG_SIN_HEADING, s);
      write_register(REG_POSE_X, ox);
      write_register(REG_POSE_Y, oy);
      write_register(REG_CELLS_PER_METRE, k);
      settings_applied++;
   endtask

   // Offers one word and returns at the edge where it is taken. The caller
   // either offers the next word at once or drops valid, never both.
   task automatic send_word(input logic [1:0] cmd, input logic [15:0] px,
                            input logic [15:0] py, input logic [13:0] ridx);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_point_x    <= px;
      req_point_y    <= py;
      req_read_index <= ridx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         CMD_POINT: point_words++;
         CMD_ROBOT: robot_words++;
         CMD_READ:  read_words++;
         default:   unused_words++;
      endcase
   endtask

   // Random sender gaps, none in the quiet tail.
   task automatic maybe_pause_sender();
      if (!quiet && $urandom_range(0, 99) < gap_percent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Waits until every expected result has come back, then idles for the given
   // extra time so that any stray result word shows. The first edge lets the checker
   // count a word taken at the current edge.
   task automatic drain_grid(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (grid_pending != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Register setting for one random phase. Two phases use the extremes of
   // every register; the rest mostly keep the pose and scale such that points
   // land inside the grid, with an occasional fully random value.
   task automatic program_phase(input int phase);
      logic [15:0] c;
      logic [15:0] s;
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] k;
      if (phase == 1) begin
         write_setting(16'(-16384), 16'(-16384), 16'h8000, 16'h7FFF, 16'hFFFF);
      end else if (phase == 4) begin
         write_setting(16'd16384, 16'd16384, 16'h7FFF, 16'h8000, 16'd1);
      end else begin
         case ($urandom_range(0, 7))
            0: begin c = 16'd16384;    s = 16'd0;        end
            1: begin c = 16'd0;        s = 16'd16384;    end
            2: begin c = 16'(-16384);  s = 16'd0;        end
            3: begin c = 16'd0;        s = 16'(-16384);  end
            4: begin c = 16'd11585;    s = 16'd11585;    end
            5: begin c = 16'd11585;    s = 16'(-11585);  end
            6: begin c = 16'(-11585);  s = 16'd11585;    end
            default: begin
               c = 16'($urandom_range(0, 32768) - 16384);
               s = 16'($urandom_range(0, 32768) - 16384);
            end
         endcase
         ox = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10240));
         oy = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10240));
         case ($urandom_range(0, 4))
            0: k = 16'd256;
            1: k = 16'd512;
            2: k = 16'd1280;
            3: k = 16'd2560;
            default: k = 16'($urandom_range(1, 65535));
         endcase
         write_setting(c, s, ox, oy, k);
      end
   endtask

   // One random word. Most are points, half of them near the robot; some replay
   // an earlier point so that a mark meets an occupied cell, and reads mostly aim at the
   // low corner of the grid where the small scales put their marks.
   task automatic send_random_word(output bit counted);
      int          roll;
      int          pick;
      logic [1:0]  cmd;
      logic [15:0] px;
      logic [15:0] py;
      logic [13:0] ridx;
      roll = $urandom_range(0, 99);
      px   = 16'($urandom);
      py   = 16'($urandom);
      ridx = 14'($urandom);
      if (roll < 55) begin
         cmd = CMD_POINT;
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            px = 16'($urandom_range(0, 16383)) - 16'd8192;
            py = 16'($urandom_range(0, 16383)) - 16'd8192;
         end else if (pick < 7 && seen_x.size() > 0) begin
            pick = $urandom_range(0, seen_x.size() - 1);
            px   = seen_x[pick];
            py   = seen_y[pick];
         end
         seen_x.insert(seen_x.size(), px);
         seen_y.insert(seen_y.size(), py);
         if (seen_x.size() > 16) begin
            void'(seen_x.pop_front());
            void'(seen_y.pop_front());
         end
      end else if (roll < 70) begin
         cmd = CMD_ROBOT;
      end else if (roll < 93) begin
         cmd = CMD_READ;
         if ($urandom_range(0, 9) < 6) begin
            ridx = 14'($urandom_range(0, 40) * GRID_W + $urandom_range(0, 40));
         end
      end else begin
         cmd = CMD_UNUSED;
      end
      maybe_pause_sender();
      send_word(cmd, px, py, ridx);
      counted = (cmd != CMD_UNUSED);
   endtask

   initial begin
      int produced;
      bit counted;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset setting: 5 cells per metre, no turn,
      // robot at the origin. A point coordinate of 205 is just over one cell,
      // 26010 just over the last column and 26215 one column past the grid.
      send_word(CMD_POINT, 16'd205, 16'd205, 14'd0);
      maybe_pause_sender();
      send_word(CMD_POINT, 16'd205, 16'd205, 14'd0);      // same cell, already marked
      send_word(CMD_POINT, 16'd26010, 16'd26010, 14'd0);  // far corner, last row and column
      maybe_pause_sender();
      send_word(CMD_POINT, 16'd26215, 16'd300, 14'd0);    // one column past the edge
      send_word(CMD_POINT, 16'd204, 16'd1000, 14'd0);     // truncates to column zero
      send_word(CMD_POINT, 16'(-205), 16'(-205), 14'd0);  // negative, truncated toward zero
      maybe_pause_sender();
      send_word(CMD_POINT, 16'h8000, 16'h7FFF, 14'd0);
      send_word(CMD_POINT, 16'h7FFF, 16'h8000, 14'd0);
      send_word(CMD_READ, 16'd0, 16'd0, 14'd129);
      send_word(CMD_READ, 16'd0, 16'd0, 14'd0);
      maybe_pause_sender();
      send_word(CMD_READ, 16'hFFFF, 16'hFFFF, 14'h3FFF);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);          // pose at the origin is not above zero
      send_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 14'h3FFF);
      drain_grid(SETTLE_CYCLES);

      // Robot one metre across and two up: its cell, then a point on that
      // same cell which must find it taken.
      write_setting(16'd16384, 16'd0, 16'd1024, 16'd2048, 16'd1280);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);
      maybe_pause_sender();
      send_word(CMD_POINT, 16'd0, 16'd0, 14'd0);
      drain_grid(SETTLE_CYCLES);

      // Largest scale with the pose at the far right: the robot column runs
      // past the grid width and spills into a later row.
      write_setting(16'(-16384), 16'd16384, 16'h7FFF, 16'd1, 16'hFFFF);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);
      send_word(CMD_POINT, 16'h8000, 16'h8000, 14'd0);
      send_word(CMD_POINT, 16'h7FFF, 16'h7FFF, 14'd0);
      send_word(CMD_READ, 16'd0, 16'd0, 14'd8191);
      drain_grid(SETTLE_CYCLES);

      // Now the linear index falls past the last cell; then the smallest
      // scale with negative poses.
      write_register(REG_POSE_Y, 16'h7FFF);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);
      drain_grid(SETTLE_CYCLES);
      write_setting(16'd16384, 16'(-16384), 16'h8000, 16'h8000, 16'd1);
      send_word(CMD_ROBOT, 16'd0, 16'd0, 14'd0);
      send_word(CMD_POINT, 16'h1234, 16'hEDCB, 14'd0);
      drain_grid(SETTLE_CYCLES);

      // Random phases, each under a fresh setting written while the block
      // is idle. The third phase carries the long receiver hold-off with the
      // sender pushing flat out; the last phase runs without any idling.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         program_phase(phase);
         case ($urandom_range(0, 2))
            0: gap_percent = 0;
            1: gap_percent = 30;
            default: gap_percent = 60;
         endcase
         case ($urandom_range(0, 2))
            0: stall_percent = 0;
            1: stall_percent = 30;
            default: stall_percent = 60;
         endcase
         if (phase == 2) begin
            gap_percent     = 0;
            squeeze_pending = 1'b1;
         end
         if (phase == NUM_PHASES - 1) begin
            quiet = 1'b1;
         end
         produced = 0;
         while (produced < PHASE_WORDS) begin
            send_random_word(counted);
            if (counted) begin
               produced++;
            end
         end
         drain_grid(SETTLE_CYCLES);
      end

      // Every result is in; give the block a few more cycles to show any
      // stray word before the verdict.
      repeat (END_CYCLES) @(posedge clock);

      $display("Covered %0d point, %0d robot, %0d read and %0d unused words over %0d settings.",
               point_words, robot_words, read_words, unused_words, settings_applied);
      $display("Compared %0d result words, including a %0d-cycle receiver hold-off.",
               grid_compared, SQUEEZE_CYCLES);
      if (grid_mismatches == 0 && grid_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results still expected",
                  grid_mismatches, grid_pending);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
